// ----- hw/rtl/brd_pkg.sv -----
package brd_pkg;

    // Stream and record geometry
    localparam int BYTE_W   = 8;
    localparam int HDR_W    = 5;
    localparam int FIELD_W  = 31;
    localparam int N_FIELDS = 4;
    localparam int CNT_W    = 5;
    // Seven leftover bits plus a full-width field
    localparam int BUF_W    = 38;
    // Bit position within a record, up to 17 bytes
    localparam int POS_W    = 8;

    // Request held in the input register
    typedef struct packed {
        logic              valid;
        logic              start;
        logic [BYTE_W-1:0] data;
    } stage_t;

endpackage

// ----- hw/rtl/bit_packed_rect_decoder_top.sv -----
// Bit-packed rectangle decoder. Takes one stream byte per request (MSB first)
// and decodes records made of a 5-bit width w followed by four signed w-bit
// fields (x_min, x_max, y_min, y_max), padded to a byte boundary. One result
// is delivered for the byte that completes a record, with the fields
// sign-extended to 31 bits, the width and the record length in bytes.
// record_start drops any partial record and begins a new one at that byte.
// A request is taken every cycle; each byte passes an input register and a
// result register, so result_valid is driven from the result register that is
// loaded when the record's last byte leaves the input register, and throughput
// drops only while a held result sits under result_stall.
module bit_packed_rect_decoder_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [brd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        record_start,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic signed [brd_pkg::FIELD_W-1:0] x_min,
    output logic signed [brd_pkg::FIELD_W-1:0] x_max,
    output logic signed [brd_pkg::FIELD_W-1:0] y_min,
    output logic signed [brd_pkg::FIELD_W-1:0] y_max,
    output logic [brd_pkg::HDR_W-1:0]   field_width,
    output logic [brd_pkg::CNT_W-1:0]   record_bytes
);

    brd_pkg::stage_t stage;
    logic            advance;

    brd_input_stage u_input
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .data_byte    (data_byte),
        .record_start (record_start),
        .advance      (advance),
        .stage        (stage)
    );

    brd_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .x_min        (x_min),
        .x_max        (x_max),
        .y_min        (y_min),
        .y_max        (y_max),
        .field_width  (field_width),
        .record_bytes (record_bytes)
    );

endmodule

// ----- hw/rtl/brd_input_stage.sv -----
module brd_input_stage
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [brd_pkg::BYTE_W-1:0] data_byte,
    input  logic                       record_start,
    input  logic                       advance,
    output brd_pkg::stage_t            stage
);

    logic                       valid_reg;
    logic                       valid_next;
    logic                       start_reg;
    logic [brd_pkg::BYTE_W-1:0] data_reg;
    logic                       accept;

    // Hold off upstream while the held request cannot move on
    assign item_stall = valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg  <= data_byte;
            start_reg <= record_start;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.start = start_reg;
    assign stage.data  = data_reg;

endmodule

// ----- hw/rtl/brd_decode.sv -----
module brd_decode
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  brd_pkg::stage_t             stage,
    output logic                        advance,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic signed [brd_pkg::FIELD_W-1:0] x_min,
    output logic signed [brd_pkg::FIELD_W-1:0] x_max,
    output logic signed [brd_pkg::FIELD_W-1:0] y_min,
    output logic signed [brd_pkg::FIELD_W-1:0] y_max,
    output logic [brd_pkg::HDR_W-1:0]   field_width,
    output logic [brd_pkg::CNT_W-1:0]   record_bytes
);

    // Record state
    logic [brd_pkg::BUF_W-1:0]   buf_reg;
    logic [brd_pkg::BUF_W-1:0]   buf_next;
    logic [brd_pkg::CNT_W-1:0]   count_reg;
    logic [brd_pkg::CNT_W-1:0]   count_next;
    logic [brd_pkg::HDR_W-1:0]   width_reg;
    logic [brd_pkg::HDR_W-1:0]   width_next;
    logic [brd_pkg::FIELD_W-1:0] field_reg  [brd_pkg::N_FIELDS];
    logic [brd_pkg::FIELD_W-1:0] field_next [brd_pkg::N_FIELDS];

    // Result register
    logic                        res_valid_reg;
    logic                        res_valid_next;
    logic [brd_pkg::FIELD_W-1:0] res_field_reg [brd_pkg::N_FIELDS];
    logic [brd_pkg::HDR_W-1:0]   res_width_reg;
    logic [brd_pkg::CNT_W-1:0]   res_bytes_reg;

    // Decode datapath
    logic [brd_pkg::CNT_W-1:0]   count_base;
    logic [brd_pkg::CNT_W-1:0]   count_inc;
    logic [brd_pkg::HDR_W-1:0]   cur_width;
    logic [brd_pkg::POS_W-1:0]   bit_total;
    logic [brd_pkg::POS_W-1:0]   end_pos   [brd_pkg::N_FIELDS];
    logic                        hit       [brd_pkg::N_FIELDS];
    logic [2:0]                  shift_amt [brd_pkg::N_FIELDS];
    logic [brd_pkg::FIELD_W-1:0] shifted   [brd_pkg::N_FIELDS];
    logic [brd_pkg::FIELD_W-1:0] field_now [brd_pkg::N_FIELDS];
    logic                        done;

    // Keep the low w bits and sign-extend them; width zero reads as zero
    function automatic logic [brd_pkg::FIELD_W-1:0] sext_field(
        input logic [brd_pkg::FIELD_W-1:0] raw,
        input logic [brd_pkg::HDR_W-1:0]   w
    );
        logic [brd_pkg::FIELD_W-1:0] mask;
        logic                        sign;
        mask = (brd_pkg::FIELD_W'(1) << w) - brd_pkg::FIELD_W'(1);
        sign = raw[w - brd_pkg::HDR_W'(1)];
        if (w == '0)
        begin
            return '0;
        end
        return (raw & mask) | (sign ? ~mask : '0);
    endfunction

    // Move on when the result register is free or being emptied
    assign advance = stage.valid && (!res_valid_reg || !result_stall);

    // Field positions follow from the byte count: header, then four w-bit fields
    always_comb
    begin
        count_base = stage.start ? '0 : count_reg;
        count_inc  = count_base + brd_pkg::CNT_W'(1);
        cur_width  = (count_base == '0) ? stage.data[brd_pkg::BYTE_W-1 -: brd_pkg::HDR_W]
                                        : width_reg;
        bit_total  = {count_inc, 3'b000};
        buf_next   = {buf_reg[brd_pkg::BUF_W-brd_pkg::BYTE_W-1:0], stage.data};

        for (int k = 0; k < brd_pkg::N_FIELDS; k++)
        begin
            end_pos[k]   = brd_pkg::POS_W'(brd_pkg::HDR_W)
                         + brd_pkg::POS_W'(k + 1) * {3'b000, cur_width};
            // Field ends inside the byte just received
            hit[k]       = (end_pos[k] <= bit_total)
                         && (({1'b0, end_pos[k]} + 9'd8) > {1'b0, bit_total});
            shift_amt[k] = 3'(bit_total - end_pos[k]);
            shifted[k]   = brd_pkg::FIELD_W'(buf_next >> shift_amt[k]);
            field_now[k] = hit[k] ? sext_field(shifted[k], cur_width) : field_reg[k];
        end

        done = (end_pos[brd_pkg::N_FIELDS-1] <= bit_total);
    end

    // Next record state
    always_comb
    begin
        count_next = count_reg;
        width_next = width_reg;
        for (int k = 0; k < brd_pkg::N_FIELDS; k++)
        begin
            field_next[k] = field_reg[k];
        end
        if (advance)
        begin
            count_next = done ? '0 : count_inc;
            width_next = cur_width;
            for (int k = 0; k < brd_pkg::N_FIELDS; k++)
            begin
                field_next[k] = field_now[k];
            end
        end
    end

    // Result valid: load on advance, clear when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = done;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            width_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            width_reg     <= width_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        buf_reg <= advance ? buf_next : buf_reg;
        for (int k = 0; k < brd_pkg::N_FIELDS; k++)
        begin
            field_reg[k] <= field_next[k];
        end
        if (advance && done)
        begin
            for (int k = 0; k < brd_pkg::N_FIELDS; k++)
            begin
                res_field_reg[k] <= field_now[k];
            end
            res_width_reg <= cur_width;
            res_bytes_reg <= count_inc;
        end
    end

    assign result_valid = res_valid_reg;
    assign x_min        = $signed(res_field_reg[0]);
    assign x_max        = $signed(res_field_reg[1]);
    assign y_min        = $signed(res_field_reg[2]);
    assign y_max        = $signed(res_field_reg[3]);
    assign field_width  = res_width_reg;
    assign record_bytes = res_bytes_reg;

`ifndef SYNTH
    // A partial record never holds more than sixteen bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= brd_pkg::CNT_W'(16))
        else $error("partial record byte count out of range");

    // Record length agrees with the decoded width
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
        record_bytes == brd_pkg::CNT_W'((9'd12 + {2'b00, field_width, 2'b00}) >> 3))
        else $error("record length does not match width");

    // Width zero yields four zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && field_width == '0) |->
        (x_min == '0 && x_max == '0 && y_min == '0 && y_max == '0))
        else $error("zero-width record has nonzero field");

    // Record state only moves when a request is consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(count_reg) && $stable(width_reg)))
        else $error("record state changed without a request");
`endif

endmodule
